FILE: rtl/core/assert_macros.svh
// assertion helpers included by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// condition that must never be seen outside reset
`define ASSERT_NEVER(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

FILE: rtl/core/swdh_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package swdh_pkg;

   // write buffer geometry
   localparam int BufferDepth = 256;
   localparam int BufAddrW    = $clog2(BufferDepth);

   // timing in 125 ns ticks
   localparam logic [18:0] TRstHigh  = 19'd400000;
   localparam logic [18:0] T10ms     = 19'd80000;
   localparam logic [18:0] T30ms     = 19'd240000;
   localparam logic [18:0] T100us    = 19'd800;
   localparam logic [18:0] THalfSlow = 19'd4000;
   localparam logic [18:0] THalfFast = 19'd2000;
   localparam logic [18:0] TDetect   = 19'd4000;

   // link opcodes and entry write
   localparam logic [1:0]  OpcSrst   = 2'd0;
   localparam logic [1:0]  OpcRotf   = 2'd1;
   localparam logic [1:0]  OpcWotf   = 2'd2;
   localparam logic [7:0]  EntryByte = 8'hA0;
   localparam logic [23:0] EntryAddr = 24'h007F80;

   // config register reset values
   localparam logic [7:0]  ShortReset   = 8'd2;
   localparam logic [7:0]  LongReset    = 8'd20;
   localparam logic [7:0]  GapReset     = 8'd22;
   localparam logic [7:0]  OneMaxReset  = 8'd8;
   localparam logic [11:0] TimeoutReset = 12'd1000;
   localparam logic [7:0]  ResendReset  = 8'd20;

   typedef enum logic [2:0] {
      CfgShort   = 3'd0,
      CfgLong    = 3'd1,
      CfgGap     = 3'd2,
      CfgOneMax  = 3'd3,
      CfgTimeout = 3'd4,
      CfgResend  = 3'd5
   } cfg_index_type;

   typedef enum logic [1:0] {
      KindTick  = 2'd0,
      KindLoad  = 2'd1,
      KindStart = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      OpEntry = 2'd0,
      OpReset = 2'd1,
      OpRead  = 2'd2,
      OpWrite = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      StatusOk      = 2'd0,
      StatusFailed  = 2'd1,
      StatusTimeout = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      SmpZero    = 2'd0,
      SmpOne     = 2'd1,
      SmpTimeout = 2'd2,
      SmpWait    = 2'd3
   } sample_type;

   typedef enum logic [4:0] {
      PhIdle, PhERstHi, PhERstLo, PhELow, PhEPulse, PhEDetect,
      PhEWaitA, PhEWaitB, PhEWaitC, PhEWaitD,
      PhSGap, PhSLow, PhSHigh, PhSAck,
      PhRBit, PhRGap, PhRLow, PhRHigh
   } phase_type;

   typedef struct packed {
      logic [7:0]  short_pulse_ticks;
      logic [7:0]  long_pulse_ticks;
      logic [7:0]  gap_ticks;
      logic [7:0]  one_max_samples;
      logic [11:0] bit_timeout_samples;
      logic [7:0]  max_resend;
   } cfg_type;

   typedef struct packed {
      logic       swim_drive;
      logic       reset_drive;
      logic       busy_res;
      logic       done_res;
      logic [1:0] status;
      logic [7:0] read_data;
      logic       read_valid;
      logic       read_last;
      logic       refused;
   } rsp_type;

endpackage
`default_nettype wire

FILE: rtl/core/swdh_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module swdh_ram #(
   parameter int Width = 8,
   parameter int Depth = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/core/swdh_engine.sv
`timescale 1ns / 1ps
`default_nettype none
module swdh_engine (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              item_take,
   input  wire logic [1:0]        kind,
   input  wire logic              swim_level,
   input  wire logic [1:0]        op,
   input  wire logic [23:0]       address,
   input  wire logic [7:0]        length,
   input  wire logic [7:0]        write_byte,
   input  wire swdh_pkg::cfg_type cfg,
   output swdh_pkg::rsp_type      result
);

   swdh_pkg::phase_type ph_ff, ph_in;
   logic [18:0] tc_ff, tc_in;
   logic [3:0]  bi_ff, bi_in;
   logic [7:0]  sb_ff, sb_in;
   logic        pa_ff, pa_in;
   logic        ss_ff, ss_in;
   logic [7:0]  ls_ff, ls_in;
   logic [11:0] ws_ff, ws_in;
   logic [7:0]  rl_ff, rl_in;
   logic [7:0]  bx_ff, bx_in;
   logic [23:0] addr_ff, addr_in;
   logic [7:0]  len_ff, len_in;
   logic [1:0]  sop_ff, sop_in;
   logic [7:0]  lc_ff, lc_in;
   logic        swim_ff, swim_in;
   logic        rst_ff, rst_in;
   logic [2:0]  seq_ff, seq_in;
   logic [1:0]  opc_ff, opc_in;
   logic        rxs_ff, rxs_in;
   logic        rxok_ff, rxok_in;
   logic        pend_ff, pend_in;

   logic        mem_we;
   logic [7:0]  mem_rdata;

   // pending buffer byte replaces the shift register contents in the cycle after the send
   logic [7:0]  sb_eff;
   logic        pa_eff;
   assign sb_eff = pend_ff ? mem_rdata : sb_ff;
   assign pa_eff = pend_ff ? ^mem_rdata : pa_ff;

   swdh_ram #(
      .Width(8),
      .Depth(swdh_pkg::BufferDepth)
   ) u_wbuf (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(lc_ff[swdh_pkg::BufAddrW-1:0]),
      .wr_data(write_byte),
      .rd_addr(bx_in[swdh_pkg::BufAddrW-1:0]),
      .rd_data(mem_rdata)
   );

   // received bit sampler
   swdh_pkg::sample_type smp_r;
   logic        smp_ss;
   logic [7:0]  smp_ls;
   logic [11:0] smp_ws;
   always_comb begin
      smp_ss = ss_ff;
      smp_ls = ls_ff;
      smp_ws = ws_ff;
      smp_r  = swdh_pkg::SmpWait;
      if (!swim_level || !ss_ff) begin
         if (!swim_level) begin
            smp_ss = 1'b1;
            if (ls_ff != 8'd255) smp_ls = ls_ff + 8'd1;
         end
         if (ws_ff != 12'd4095) smp_ws = ws_ff + 12'd1;
         if (smp_ws >= cfg.bit_timeout_samples) smp_r = swdh_pkg::SmpTimeout;
      end else begin
         smp_r = (ls_ff <= cfg.one_max_samples) ? swdh_pkg::SmpOne : swdh_pkg::SmpZero;
      end
   end

   // bit being sent
   logic [3:0] nbits;
   logic [3:0] bit_pos;
   logic       tx_bit;
   always_comb begin
      nbits   = (seq_ff == 3'd0) ? 4'd3 : 4'd8;
      bit_pos = nbits - bi_ff;
      if (bi_ff == 4'd0) tx_bit = 1'b0;
      else if (bi_ff <= nbits) tx_bit = sb_eff[bit_pos[2:0]];
      else tx_bit = pa_eff;
   end

   // state update for one item
   always_comb begin
      logic [18:0] tc_inc;
      logic [7:0]  thr;
      logic        send_req;
      logic        wait_req;
      logic        recv_req;
      logic        seq_done;
      logic        unit_ok;
      logic        last_byte;
      logic [7:0]  send_byte;
      logic [7:0]  send_retry;
      swdh_pkg::phase_type wait_ph;

      ph_in = ph_ff;     tc_in = tc_ff;     bi_in = bi_ff;     sb_in = sb_eff;
      pa_in = pa_eff;    ss_in = ss_ff;     ls_in = ls_ff;     ws_in = ws_ff;
      rl_in = rl_ff;     bx_in = bx_ff;     addr_in = addr_ff; len_in = len_ff;
      sop_in = sop_ff;   lc_in = lc_ff;     swim_in = swim_ff; rst_in = rst_ff;
      seq_in = seq_ff;   opc_in = opc_ff;   rxs_in = rxs_ff;   rxok_in = rxok_ff;
      pend_in = 1'b0;
      mem_we = 1'b0;
      result = '0;
      tc_inc = tc_ff + 19'd1;
      thr = 8'd0;
      send_req = 1'b0;
      wait_req = 1'b0;
      recv_req = 1'b0;
      seq_done = 1'b0;
      unit_ok = 1'b0;
      last_byte = ({1'b0, bx_ff} + 9'd1) >= {1'b0, len_ff};
      send_byte = 8'd0;
      send_retry = 8'd0;
      wait_ph = swdh_pkg::PhRBit;

      if (item_take) begin
         if (kind == swdh_pkg::KindLoad || kind == swdh_pkg::KindStart) begin
            if (ph_ff != swdh_pkg::PhIdle) begin
               result.refused = 1'b1;
            end else if (kind == swdh_pkg::KindLoad) begin
               mem_we = 1'b1;
               lc_in = lc_ff + 8'd1;
            end else begin
               sop_in = op;
               lc_in = 8'd0;
               if (op == swdh_pkg::OpEntry) begin
                  swim_in = 1'b1;
                  rst_in = 1'b1;
                  ph_in = swdh_pkg::PhERstHi;
                  tc_in = '0;
               end else if (op == swdh_pkg::OpReset) begin
                  opc_in = swdh_pkg::OpcSrst;
                  seq_in = 3'd0;
                  send_req = 1'b1;
               end else begin
                  addr_in = address;
                  len_in = length;
                  if (length == 8'd0) begin
                     ph_in = swdh_pkg::PhIdle;
                     result.done_res = 1'b1;
                     result.status = swdh_pkg::StatusOk;
                  end else begin
                     opc_in = (op == swdh_pkg::OpRead) ? swdh_pkg::OpcRotf : swdh_pkg::OpcWotf;
                     seq_in = 3'd0;
                     send_req = 1'b1;
                  end
               end
            end
         end else if (kind == swdh_pkg::KindTick && ph_ff != swdh_pkg::PhIdle) begin
            tc_in = tc_inc;
            unique case (ph_ff)
               swdh_pkg::PhERstHi: begin
                  if (tc_inc >= swdh_pkg::TRstHigh) begin
                     rst_in = 1'b0;
                     ph_in = swdh_pkg::PhERstLo;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhERstLo: begin
                  if (tc_inc >= swdh_pkg::T10ms) begin
                     swim_in = 1'b0;
                     ph_in = swdh_pkg::PhELow;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhELow: begin
                  if (tc_inc >= swdh_pkg::T100us) begin
                     bi_in = 4'd0;
                     swim_in = 1'b1;
                     ph_in = swdh_pkg::PhEPulse;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhEPulse: begin
                  if (tc_inc >= ((bi_ff < 4'd8) ? swdh_pkg::THalfSlow : swdh_pkg::THalfFast))
                  begin
                     if (bi_ff == 4'd15) begin
                        swim_in = 1'b1;
                        ss_in = 1'b0;
                        rxok_in = 1'b0;
                        ph_in = swdh_pkg::PhEDetect;
                     end else begin
                        bi_in = bi_ff + 4'd1;
                        swim_in = bi_ff[0];
                     end
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhEDetect: begin
                  if (tc_inc[1:0] == 2'd0) begin
                     if (!swim_level) ss_in = 1'b1;
                     else if (ss_ff) rxok_in = 1'b1;
                  end
                  if (tc_inc >= swdh_pkg::TDetect) begin
                     if (rxok_in) begin
                        ph_in = swdh_pkg::PhEWaitA;
                        tc_in = '0;
                     end else begin
                        ph_in = swdh_pkg::PhIdle;
                        result.done_res = 1'b1;
                        result.status = swdh_pkg::StatusFailed;
                     end
                  end
               end
               swdh_pkg::PhEWaitA: begin
                  if (tc_inc >= swdh_pkg::T10ms) begin
                     opc_in = swdh_pkg::OpcSrst;
                     seq_in = 3'd0;
                     send_req = 1'b1;
                  end
               end
               swdh_pkg::PhEWaitB: begin
                  if (tc_inc >= swdh_pkg::T30ms) begin
                     opc_in = swdh_pkg::OpcWotf;
                     addr_in = swdh_pkg::EntryAddr;
                     len_in = 8'd1;
                     seq_in = 3'd0;
                     send_req = 1'b1;
                  end
               end
               swdh_pkg::PhEWaitC: begin
                  if (tc_inc >= swdh_pkg::T10ms) begin
                     rst_in = 1'b1;
                     ph_in = swdh_pkg::PhEWaitD;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhEWaitD: begin
                  if (tc_inc >= swdh_pkg::T10ms) begin
                     ph_in = swdh_pkg::PhIdle;
                     result.done_res = 1'b1;
                     result.status = swdh_pkg::StatusOk;
                  end
               end
               swdh_pkg::PhSGap: begin
                  if (tc_inc >= {11'd0, cfg.gap_ticks}) begin
                     bi_in = 4'd0;
                     swim_in = 1'b0;
                     ph_in = swdh_pkg::PhSLow;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhSLow: begin
                  thr = tx_bit ? cfg.short_pulse_ticks : cfg.long_pulse_ticks;
                  if (thr == 8'd0) thr = 8'd1;
                  if (tc_inc >= {11'd0, thr}) begin
                     swim_in = 1'b1;
                     ph_in = swdh_pkg::PhSHigh;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhSHigh: begin
                  thr = tx_bit ? cfg.long_pulse_ticks : cfg.short_pulse_ticks;
                  if (thr == 8'd0) thr = 8'd1;
                  if (tc_inc >= {11'd0, thr}) begin
                     if (bi_ff >= nbits + 4'd1) begin
                        wait_req = 1'b1;
                        wait_ph = swdh_pkg::PhSAck;
                     end else begin
                        bi_in = bi_ff + 4'd1;
                        swim_in = 1'b0;
                        ph_in = swdh_pkg::PhSLow;
                        tc_in = '0;
                     end
                  end
               end
               swdh_pkg::PhSAck: begin
                  ss_in = smp_ss;
                  ls_in = smp_ls;
                  ws_in = smp_ws;
                  unique case (smp_r)
                     swdh_pkg::SmpTimeout: begin
                        ph_in = swdh_pkg::PhIdle;
                        result.done_res = 1'b1;
                        result.status = swdh_pkg::StatusTimeout;
                     end
                     swdh_pkg::SmpOne: unit_ok = 1'b1;
                     swdh_pkg::SmpZero: begin
                        if (rl_ff != 8'd0) begin
                           rl_in = rl_ff - 8'd1;
                           bi_in = 4'd0;
                           swim_in = 1'b0;
                           ph_in = swdh_pkg::PhSLow;
                           tc_in = '0;
                        end else begin
                           ph_in = swdh_pkg::PhIdle;
                           result.done_res = 1'b1;
                           result.status = swdh_pkg::StatusFailed;
                        end
                     end
                     swdh_pkg::SmpWait: begin
                     end
                     default: begin
                     end
                  endcase
               end
               swdh_pkg::PhRBit: begin
                  ss_in = smp_ss;
                  ls_in = smp_ls;
                  ws_in = smp_ws;
                  if (smp_r == swdh_pkg::SmpTimeout) begin
                     ph_in = swdh_pkg::PhIdle;
                     result.done_res = 1'b1;
                     result.status = swdh_pkg::StatusTimeout;
                  end else if (smp_r != swdh_pkg::SmpWait) begin
                     if (bi_ff == 4'd0 || bi_ff <= 4'd8) begin
                        if (bi_ff == 4'd0) begin
                           rxs_in = smp_r[0];
                        end else begin
                           sb_in = {sb_eff[6:0], smp_r[0]};
                           pa_in = pa_eff ^ smp_r[0];
                        end
                        bi_in = bi_ff + 4'd1;
                        wait_req = 1'b1;
                        wait_ph = swdh_pkg::PhRBit;
                     end else begin
                        rxok_in = rxs_ff && (smp_r[0] == pa_eff);
                        if (rxok_in) begin
                           result.read_valid = 1'b1;
                           result.read_data = sb_eff;
                           result.read_last = last_byte;
                        end
                        tc_in = '0;
                        if (cfg.gap_ticks == 8'd0) begin
                           swim_in = 1'b0;
                           ph_in = swdh_pkg::PhRLow;
                        end else begin
                           swim_in = 1'b1;
                           ph_in = swdh_pkg::PhRGap;
                        end
                     end
                  end
               end
               swdh_pkg::PhRGap: begin
                  if (tc_inc >= {11'd0, cfg.gap_ticks}) begin
                     swim_in = 1'b0;
                     ph_in = swdh_pkg::PhRLow;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhRLow: begin
                  thr = rxok_ff ? cfg.short_pulse_ticks : cfg.long_pulse_ticks;
                  if (thr == 8'd0) thr = 8'd1;
                  if (tc_inc >= {11'd0, thr}) begin
                     swim_in = 1'b1;
                     ph_in = swdh_pkg::PhRHigh;
                     tc_in = '0;
                  end
               end
               swdh_pkg::PhRHigh: begin
                  thr = rxok_ff ? cfg.long_pulse_ticks : cfg.short_pulse_ticks;
                  if (thr == 8'd0) thr = 8'd1;
                  if (tc_inc >= {11'd0, thr}) begin
                     if (!rxok_ff || last_byte) begin
                        ph_in = swdh_pkg::PhIdle;
                        result.done_res = 1'b1;
                        result.status = rxok_ff ? swdh_pkg::StatusOk
                                                : swdh_pkg::StatusFailed;
                     end else begin
                        bx_in = bx_ff + 8'd1;
                        recv_req = 1'b1;
                     end
                  end
               end
               default: ph_in = swdh_pkg::PhIdle;
            endcase
         end
      end

      // ack accepted: advance through the command frames
      if (unit_ok) begin
         if (opc_ff == swdh_pkg::OpcSrst) begin
            seq_done = 1'b1;
         end else if (seq_ff < 3'd4) begin
            seq_in = seq_ff + 3'd1;
            send_req = 1'b1;
         end else if (seq_ff == 3'd4) begin
            bx_in = 8'd0;
            seq_in = 3'd5;
            if (opc_ff == swdh_pkg::OpcRotf) recv_req = 1'b1;
            else send_req = 1'b1;
         end else if (last_byte) begin
            seq_done = 1'b1;
         end else begin
            bx_in = bx_ff + 8'd1;
            send_req = 1'b1;
         end
      end

      // command sequence complete
      if (seq_done) begin
         if (sop_ff != swdh_pkg::OpEntry) begin
            ph_in = swdh_pkg::PhIdle;
            result.done_res = 1'b1;
            result.status = swdh_pkg::StatusOk;
         end else begin
            swim_in = 1'b1;
            ph_in = (opc_ff == swdh_pkg::OpcSrst) ? swdh_pkg::PhEWaitB : swdh_pkg::PhEWaitC;
            tc_in = '0;
         end
      end

      // start of a received byte
      if (recv_req) begin
         bi_in = 4'd0;
         sb_in = 8'd0;
         pa_in = 1'b0;
         rxs_in = 1'b0;
         wait_req = 1'b1;
         wait_ph = swdh_pkg::PhRBit;
      end

      // wait for a bit from the target
      if (wait_req) begin
         ss_in = 1'b0;
         ls_in = 8'd0;
         ws_in = 12'd0;
         swim_in = 1'b1;
         ph_in = wait_ph;
         tc_in = '0;
      end

      // load the next frame to send
      if (send_req) begin
         send_retry = cfg.max_resend;
         unique case (seq_in)
            3'd0: send_byte = {6'd0, opc_in};
            3'd1: begin
               send_byte = len_in;
               send_retry = 8'd0;
            end
            3'd2: begin
               send_byte = addr_in[23:16];
               send_retry = 8'd0;
            end
            3'd3: begin
               send_byte = addr_in[15:8];
               send_retry = 8'd0;
            end
            3'd4: begin
               send_byte = addr_in[7:0];
               send_retry = 8'd0;
            end
            default: send_byte = swdh_pkg::EntryByte;
         endcase
         if (seq_in == 3'd0) send_byte = {5'd0, send_byte[2:0]};
         if (seq_in >= 3'd5 && sop_in != swdh_pkg::OpEntry) begin
            pend_in = 1'b1;
            sb_in = 8'd0;
            pa_in = 1'b0;
         end else begin
            sb_in = send_byte;
            pa_in = ^send_byte;
         end
         rl_in = send_retry;
         tc_in = '0;
         if (cfg.gap_ticks == 8'd0) begin
            bi_in = 4'd0;
            swim_in = 1'b0;
            ph_in = swdh_pkg::PhSLow;
         end else begin
            swim_in = 1'b1;
            ph_in = swdh_pkg::PhSGap;
         end
      end

      result.swim_drive = swim_in;
      result.reset_drive = rst_in;
      result.busy_res = (ph_in != swdh_pkg::PhIdle);
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= swdh_pkg::PhIdle;
         tc_ff <= '0;      bi_ff <= '0;     sb_ff <= '0;     pa_ff <= 1'b0;
         ss_ff <= 1'b0;    ls_ff <= '0;     ws_ff <= '0;     rl_ff <= '0;
         bx_ff <= '0;      addr_ff <= '0;   len_ff <= '0;    sop_ff <= '0;
         lc_ff <= '0;      swim_ff <= 1'b1; rst_ff <= 1'b1;  seq_ff <= '0;
         opc_ff <= '0;     rxs_ff <= 1'b0;  rxok_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         tc_ff <= tc_in;   bi_ff <= bi_in;     sb_ff <= sb_in;     pa_ff <= pa_in;
         ss_ff <= ss_in;   ls_ff <= ls_in;     ws_ff <= ws_in;     rl_ff <= rl_in;
         bx_ff <= bx_in;   addr_ff <= addr_in; len_ff <= len_in;   sop_ff <= sop_in;
         lc_ff <= lc_in;   swim_ff <= swim_in; rst_ff <= rst_in;   seq_ff <= seq_in;
         opc_ff <= opc_in; rxs_ff <= rxs_in;   rxok_ff <= rxok_in; pend_ff <= pend_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/single_wire_debug_host_core.sv
`timescale 1ns / 1ps
`default_nettype none
// channel   direction  beat
// req_      in         tick with line sample, load write byte or start command
// rsp_      out        drive levels, busy, done, status, read byte, refused
// csr_      in         register index and write data
//
// one req beat is taken per cycle while req_ready is high; each gives one registered rsp beat
// results sit in an output register backed by one skid entry
// req_ready drops only while the skid entry is full
// the write buffer is a 256 x 8 ram; a buffered byte is fetched the cycle after its frame starts
// synchronous active high reset; engine drive registers come up released high, the engine idle
`include "assert_macros.svh"
module single_wire_debug_host_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic        req_swim_level,
   input  wire logic [1:0]  req_op,
   input  wire logic [23:0] req_address,
   input  wire logic [7:0]  req_length,
   input  wire logic [7:0]  req_write_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_swim_drive,
   output logic             rsp_reset_drive,
   output logic             rsp_busy_res,
   output logic             rsp_done_res,
   output logic [1:0]       rsp_status,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_read_valid,
   output logic             rsp_read_last,
   output logic             rsp_refused,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [2:0]  csr_index,
   input  wire logic [11:0] csr_data
);

   swdh_pkg::cfg_type cfg_ff;
   swdh_pkg::rsp_type eng_rsp;
   swdh_pkg::rsp_type out_ff, skid_ff;
   logic out_valid_ff, skid_valid_ff;
   logic req_take;

   assign csr_ready = 1'b1;
   assign req_ready = !skid_valid_ff;
   assign req_take  = req_valid && req_ready;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.short_pulse_ticks   <= swdh_pkg::ShortReset;
         cfg_ff.long_pulse_ticks    <= swdh_pkg::LongReset;
         cfg_ff.gap_ticks           <= swdh_pkg::GapReset;
         cfg_ff.one_max_samples     <= swdh_pkg::OneMaxReset;
         cfg_ff.bit_timeout_samples <= swdh_pkg::TimeoutReset;
         cfg_ff.max_resend          <= swdh_pkg::ResendReset;
      end else if (csr_valid) begin
         unique case (csr_index)
            swdh_pkg::CfgShort:   cfg_ff.short_pulse_ticks   <= csr_data[7:0];
            swdh_pkg::CfgLong:    cfg_ff.long_pulse_ticks    <= csr_data[7:0];
            swdh_pkg::CfgGap:     cfg_ff.gap_ticks           <= csr_data[7:0];
            swdh_pkg::CfgOneMax:  cfg_ff.one_max_samples     <= csr_data[7:0];
            swdh_pkg::CfgTimeout: cfg_ff.bit_timeout_samples <= csr_data;
            swdh_pkg::CfgResend:  cfg_ff.max_resend          <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   swdh_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .item_take (req_take),
      .kind      (req_kind),
      .swim_level(req_swim_level),
      .op        (req_op),
      .address   (req_address),
      .length    (req_length),
      .write_byte(req_write_byte),
      .cfg       (cfg_ff),
      .result    (eng_rsp)
   );

   // output register with skid entry
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_take) begin
         if (out_valid_ff && !rsp_ready) skid_valid_ff <= 1'b1;
         else out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) out_ff <= skid_ff;
      end else if (req_take) begin
         if (out_valid_ff && !rsp_ready) skid_ff <= eng_rsp;
         else out_ff <= eng_rsp;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_swim_drive  = out_ff.swim_drive;
   assign rsp_reset_drive = out_ff.reset_drive;
   assign rsp_busy_res    = out_ff.busy_res;
   assign rsp_done_res    = out_ff.done_res;
   assign rsp_status      = out_ff.status;
   assign rsp_read_data   = out_ff.read_data;
   assign rsp_read_valid  = out_ff.read_valid;
   assign rsp_read_last   = out_ff.read_last;
   assign rsp_refused     = out_ff.refused;

   `ASSERT_CLK(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid full with output empty")
   `ASSERT_CLK(a_skid_drains, (skid_valid_ff && rsp_ready) |=> (out_valid_ff && !skid_valid_ff), "skid not drained")
   `ASSERT_NEVER(a_done_busy, rsp_valid && rsp_done_res && rsp_busy_res, "done beat still busy")
   `ASSERT_NEVER(a_last_alone, rsp_valid && rsp_read_last && !rsp_read_valid, "read_last without data")

endmodule
`default_nettype wire
